[hdl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int NUM_ELEM    = 9;
   localparam int WORD_W      = 32;
   localparam int COF_W       = 64;
   localparam int DET_W       = 97;
   localparam int DMAG_W      = 96;
   localparam int QBITS       = 32;
   localparam int FRONT_DEPTH = 6;
   localparam int LANE_DEPTH  = QBITS + 2;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + LANE_DEPTH;

   localparam logic [WORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] Q_MIN = 32'h8000_0000;

   // Element indices a..i in row order
   localparam int EA = 0, EB = 1, EC = 2, ED = 3, EE = 4;
   localparam int EF = 5, EG = 6, EH = 7, EI = 8;

   // Cofactor k = m[x]*m[y] - m[z]*m[w], adjugate already transposed
   localparam int COF_IDX [NUM_ELEM][4] = '{
      '{EE, EI, EF, EH}, '{EC, EH, EB, EI}, '{EB, EF, EC, EE},
      '{EF, EG, ED, EI}, '{EA, EI, EC, EG}, '{EC, ED, EA, EF},
      '{ED, EH, EE, EG}, '{EG, EB, EA, EH}, '{EA, EE, EB, ED}
   };

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [COF_W-1:0] mag;
      logic             neg;
   } cof_mag_type;

   typedef struct packed {
      logic [DMAG_W-1:0] mag;
      logic              neg;
      logic              sing;
   } det_info_type;

endpackage

[hdl/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det
// Cofactor and determinant pipeline: exact products, six register stages.
// ----------------------------------------------------------------------------
module mi3_det (
   input  logic                    clock,
   input  logic                    en,
   input  mi3_pkg::word_type       m [mi3_pkg::NUM_ELEM],
   output mi3_pkg::cof_mag_type    cof [mi3_pkg::NUM_ELEM],
   output mi3_pkg::det_info_type   det
);

   localparam int N = mi3_pkg::NUM_ELEM;
   localparam int CW = mi3_pkg::COF_W;
   localparam int DW = mi3_pkg::DET_W;
   localparam int WW = mi3_pkg::WORD_W;

   logic signed [CW-1:0]   pa_ff [N];
   logic signed [CW-1:0]   pb_ff [N];
   logic signed [CW-1:0]   cof_ff [N];
   mi3_pkg::word_type      abc1_ff [3];
   mi3_pkg::word_type      abc2_ff [3];
   logic signed [WW+CW/2:0]  lo_ff [3];
   logic signed [CW-1:0]   hi_ff [3];
   logic signed [DW-1:0]   term_ff [3];
   logic signed [DW-1:0]   sum_ff;
   mi3_pkg::cof_mag_type   cm3_ff [N];
   mi3_pkg::cof_mag_type   cm4_ff [N];
   mi3_pkg::cof_mag_type   cm5_ff [N];
   mi3_pkg::cof_mag_type   cm6_ff [N];
   mi3_pkg::det_info_type  det_ff;

   // Stage 1 and 2: element products, then cofactor differences
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            pa_ff[k]  <= CW'(m[mi3_pkg::COF_IDX[k][0]]) * CW'(m[mi3_pkg::COF_IDX[k][1]]);
            pb_ff[k]  <= CW'(m[mi3_pkg::COF_IDX[k][2]]) * CW'(m[mi3_pkg::COF_IDX[k][3]]);
            cof_ff[k] <= pa_ff[k] - pb_ff[k];
         end
         abc1_ff[0] <= m[mi3_pkg::EA];
         abc1_ff[1] <= m[mi3_pkg::EB];
         abc1_ff[2] <= m[mi3_pkg::EC];
         abc2_ff    <= abc1_ff;
      end
   end

   // Stage 3 and 4: split first-row times cofactor into 32-bit halves, then rejoin
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            lo_ff[j] <= (WW+CW/2+1)'(abc2_ff[j]) *
                        $signed({1'b0, cof_ff[3*j][CW/2-1:0]});
            hi_ff[j] <= CW'(abc2_ff[j]) * CW'($signed(cof_ff[3*j][CW-1:CW/2]));
            term_ff[j] <= (DW'(hi_ff[j]) <<< (CW/2)) + DW'(lo_ff[j]);
         end
         for (int k = 0; k < N; k++) begin
            cm3_ff[k].neg <= cof_ff[k][CW-1];
            cm3_ff[k].mag <= cof_ff[k][CW-1] ? CW'(-cof_ff[k]) : CW'(cof_ff[k]);
         end
         cm4_ff <= cm3_ff;
      end
   end

   // Stage 5 and 6: sum the expansion, take sign and magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff      <= term_ff[0] + term_ff[1] + term_ff[2];
         det_ff.neg  <= sum_ff[DW-1];
         det_ff.mag  <= sum_ff[DW-1] ? (DW-1)'(-sum_ff) : (DW-1)'(sum_ff);
         det_ff.sing <= (sum_ff == '0);
         cm5_ff      <= cm4_ff;
         cm6_ff      <= cm5_ff;
      end
   end

   assign cof = cm6_ff;
   assign det = det_ff;

endmodule

[hdl/mi3_lane.sv]
// ----------------------------------------------------------------------------
// mi3_lane
// One element lane: restoring divide, one quotient bit per stage, then
// floor rounding and saturation to Q16.16.
// ----------------------------------------------------------------------------
module mi3_lane (
   input  logic                   clock,
   input  logic                   en,
   input  mi3_pkg::cof_mag_type   cof,
   input  mi3_pkg::det_info_type  det,
   output logic [mi3_pkg::WORD_W-1:0] res
);

   localparam int QB = mi3_pkg::QBITS;
   localparam int DM = mi3_pkg::DMAG_W;

   logic [DM-1:0]  r_ff [QB+1];
   logic [DM-1:0]  d_ff [QB];
   logic [QB-1:0]  q_ff [QB+1];
   logic           neg_ff [QB+1];
   logic           sat_ff [QB+1];
   logic           sing_ff [QB+1];
   logic [mi3_pkg::WORD_W-1:0] res_ff;

   // Entry stage: quotient of 2^32 or more saturates
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= DM'(cof.mag);
         d_ff[0]    <= det.mag;
         q_ff[0]    <= '0;
         neg_ff[0]  <= cof.neg ^ det.neg;
         sat_ff[0]  <= (DM'(cof.mag) >= det.mag);
         sing_ff[0] <= det.sing;
      end
   end

   // Divide steps
   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [DM:0] t;
      logic        ge;
      assign t  = {r_ff[k-1], 1'b0};
      assign ge = (t >= {1'b0, d_ff[k-1]});
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]    <= ge ? DM'(t - {1'b0, d_ff[k-1]}) : t[DM-1:0];
            q_ff[k]    <= {q_ff[k-1][QB-2:0], ge};
            neg_ff[k]  <= neg_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
            sing_ff[k] <= sing_ff[k-1];
         end
      end
      // Carry the divisor on to the next step
      if (k < QB) begin : g_dly
         always_ff @(posedge clock) begin
            if (en) begin
               d_ff[k] <= d_ff[k-1];
            end
         end
      end
   end

   // Round toward negative infinity and saturate
   always_ff @(posedge clock) begin
      if (en) begin
         priority if (sing_ff[QB]) begin
            res_ff <= '0;
         end else if (sat_ff[QB] || q_ff[QB][QB-1]) begin
            res_ff <= neg_ff[QB] ? mi3_pkg::Q_MIN : mi3_pkg::Q_MAX;
         end else if (!neg_ff[QB]) begin
            res_ff <= q_ff[QB];
         end else begin
            res_ff <= -(q_ff[QB] + QB'(r_ff[QB] != '0));
         end
      end
   end

   assign res = res_ff;

endmodule

[hdl/matrix3_inverse_core.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a signed Q16.16 3x3 matrix by the adjugate over the determinant.
// ----------------------------------------------------------------------------
// One matrix is taken every cycle while the pipeline advances; its inverse comes
// from six stages of exact cofactor and determinant products, then nine divider
// lanes of 34 stages, one quotient bit per stage. The whole pipeline holds
// while a result waits and rsp_tready is low. Elements are floored and
// saturated; a zero determinant gives zero elements and rsp_tuser high.
module matrix3_inverse_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,   // m00 m01 m02 m10 m11 m12 m20 m21 m22, 32 bits each
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22, 32 bits each
   output logic [0:0]   rsp_tuser    // singular
);

   localparam int N  = mi3_pkg::NUM_ELEM;
   localparam int WW = mi3_pkg::WORD_W;
   localparam int PD = mi3_pkg::PIPE_DEPTH;
   localparam int LD = mi3_pkg::LANE_DEPTH;

   logic                  en;
   logic                  vld_ff [PD];
   logic                  sing_ff [LD];
   mi3_pkg::word_type     m [N];
   mi3_pkg::cof_mag_type  cof [N];
   mi3_pkg::det_info_type det;
   logic [WW-1:0]         res [N];

   // Advance whenever the output slot is free or being taken
   assign en         = !vld_ff[PD-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[PD-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PD; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < PD; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_unpack
      assign m[k] = req_tdata[k*WW +: WW];
   end

   mi3_det u_det (
      .clock (clock),
      .en    (en),
      .m     (m),
      .cof   (cof),
      .det   (det)
   );

   for (genvar k = 0; k < N; k++) begin : g_lane
      mi3_lane u_lane (
         .clock (clock),
         .en    (en),
         .cof   (cof[k]),
         .det   (det),
         .res   (res[k])
      );
      assign rsp_tdata[k*WW +: WW] = res[k];
   end

   // Carry the singular flag alongside the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= det.sing;
         for (int k = 1; k < LD; k++) sing_ff[k] <= sing_ff[k-1];
      end
   end

   assign rsp_tuser = sing_ff[LD-1];

endmodule
